FILE: rtl/core/phd_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// phd_pkg
// Shared types, codes and defaults for the peak hold with stepped decay block.
// ----------------------------------------------------------------------------
package phd_pkg;

  localparam int SAMPLE_BITS_DEFAULT = 16;
  localparam int CFG_BITS            = 16;
  localparam int CFG_INDEX_BITS      = 2;
  localparam int PHASE_BITS          = 3;

  localparam logic [CFG_BITS-1:0] HOLD_SAMPLES_RESET   = 16'd100;
  localparam logic [CFG_BITS-1:0] DECAY_INTERVAL_RESET = 16'd10;
  localparam logic [CFG_BITS-1:0] DECAY_STEP_RESET     = 16'd1;

  typedef enum logic [CFG_INDEX_BITS-1:0] {
    REG_TRACK_MINIMUM  = 2'd0,
    REG_HOLD_SAMPLES   = 2'd1,
    REG_DECAY_INTERVAL = 2'd2,
    REG_DECAY_STEP     = 2'd3
  } cfg_reg_t;

  localparam logic [PHASE_BITS-1:0] PHASE_IDLE     = 3'd0;
  localparam logic [PHASE_BITS-1:0] PHASE_CAPTURED = 3'd1;
  localparam logic [PHASE_BITS-1:0] PHASE_HOLDING  = 3'd2;
  localparam logic [PHASE_BITS-1:0] PHASE_STEP     = 3'd3;
  localparam logic [PHASE_BITS-1:0] PHASE_WAIT     = 3'd4;
  localparam logic [PHASE_BITS-1:0] PHASE_CHECK    = 3'd5;

  typedef enum logic [5:0] {
    ST_IDLE     = 6'b000001,
    ST_CAPTURED = 6'b000010,
    ST_HOLDING  = 6'b000100,
    ST_STEP     = 6'b001000,
    ST_WAIT     = 6'b010000,
    ST_CHECK    = 6'b100000
  } phase_state_t;

  typedef struct packed {
    logic                track_minimum;
    logic [CFG_BITS-1:0] hold_samples;
    logic [CFG_BITS-1:0] decay_interval;
    logic [CFG_BITS-1:0] decay_step;
  } cfg_t;

  function automatic logic [PHASE_BITS-1:0] phase_code(input phase_state_t st);
    logic [PHASE_BITS-1:0] code;
    case (st)
      ST_IDLE:     code = PHASE_IDLE;
      ST_CAPTURED: code = PHASE_CAPTURED;
      ST_HOLDING:  code = PHASE_HOLDING;
      ST_STEP:     code = PHASE_STEP;
      ST_WAIT:     code = PHASE_WAIT;
      ST_CHECK:    code = PHASE_CHECK;
      default:     code = PHASE_IDLE;
    endcase
    return code;
  endfunction

endpackage
`default_nettype wire

FILE: rtl/core/phd_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// phd_sample_if / phd_result_if
// Valid/ready channels for samples in and held results out.
// ----------------------------------------------------------------------------
interface phd_sample_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface phd_result_if #(
  parameter int SAMPLE_BITS = 16
);
  logic                   valid;
  logic                   ready;
  logic [SAMPLE_BITS-1:0] held_value;
  logic [2:0]             phase;

  modport source (output valid, output held_value, output phase, input ready);
  modport sink   (input valid, input held_value, input phase, output ready);
endinterface
`default_nettype wire

FILE: rtl/core/phd_tracker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// phd_tracker
// Held extreme, phase and wait counter; one step per sample beat.
// ----------------------------------------------------------------------------
module phd_tracker
  import phd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire logic                   step_en,
  input  wire logic [SAMPLE_BITS-1:0] sample,
  input  wire cfg_t                   cfg,
  input  wire logic                   restart,
  input  wire logic                   restart_minimum,
  output logic      [SAMPLE_BITS-1:0] held_next,
  output logic      [PHASE_BITS-1:0]  phase_next
);

  localparam int EXT_BITS = ((SAMPLE_BITS > CFG_BITS) ? SAMPLE_BITS : CFG_BITS) + 1;
  localparam logic [EXT_BITS-1:0] RANGE_MAX = EXT_BITS'({SAMPLE_BITS{1'b1}});

  logic [SAMPLE_BITS-1:0] held;
  phase_state_t           state;
  logic [CFG_BITS-1:0]    wait_count;

  phase_state_t           state_next;
  logic [CFG_BITS-1:0]    wait_count_next;

  logic [EXT_BITS-1:0]    held_x;
  logic [EXT_BITS-1:0]    step_x;
  logic [EXT_BITS-1:0]    up_sum;
  logic                   beyond;
  logic                   more;

  assign held_x = EXT_BITS'(held);
  assign step_x = EXT_BITS'(cfg.decay_step);
  assign up_sum = held_x + step_x;
  assign beyond = cfg.track_minimum ? (sample < held) : (sample > held);
  assign more   = cfg.track_minimum ? (up_sum < RANGE_MAX) : (held_x > step_x);

  always_comb begin
    held_next       = held;
    state_next      = state;
    wait_count_next = wait_count;
    if (beyond) begin
      held_next  = sample;
      state_next = ST_CAPTURED;
    end else begin
      case (state)
        ST_CAPTURED: begin
          wait_count_next = cfg.hold_samples;
          state_next      = ST_HOLDING;
        end
        ST_HOLDING, ST_WAIT: begin
          if (wait_count != '0) begin
            wait_count_next = wait_count - 1'b1;
          end else begin
            state_next = (state == ST_HOLDING) ? ST_STEP : ST_CHECK;
          end
        end
        ST_STEP: begin
          if (cfg.track_minimum) begin
            held_next = (up_sum > RANGE_MAX) ? {SAMPLE_BITS{1'b1}}
                                             : up_sum[SAMPLE_BITS-1:0];
          end else begin
            held_next = (held_x > step_x) ? SAMPLE_BITS'(held_x - step_x) : '0;
          end
          wait_count_next = cfg.decay_interval;
          state_next      = ST_WAIT;
        end
        ST_CHECK: begin
          state_next = more ? ST_STEP : ST_IDLE;
        end
        default: begin
          state_next = state;
        end
      endcase
    end
  end

  assign phase_next = phase_code(state_next);

  always_ff @(posedge clk) begin
    if (rst) begin
      held       <= '0;
      state      <= ST_IDLE;
      wait_count <= '0;
    end else if (restart) begin
      held       <= restart_minimum ? {SAMPLE_BITS{1'b1}} : '0;
      state      <= ST_IDLE;
      wait_count <= '0;
    end else if (step_en) begin
      held       <= held_next;
      state      <= state_next;
      wait_count <= wait_count_next;
    end
  end

endmodule
`default_nettype wire

FILE: rtl/core/peak_hold_with_stepped_decay.sv
`default_nettype none
// ----------------------------------------------------------------------------
// peak_hold_with_stepped_decay
// Tracks the running maximum or minimum of a sample stream with hold and
// stepped decay toward the end of the range.
// ----------------------------------------------------------------------------
// One sample beat in gives one result beat out, holding the extreme after that
// sample and its phase. A sample is taken every cycle unless output stalls;
// it is held in the input register, the tracker steps on it and its result
// goes to the output register. The user must make register writes (mode,
// hold count, decay interval, decay step) only while no sample is in flight;
// the block does not enforce it; a mode write restarts from the range end.
module peak_hold_with_stepped_decay
  import phd_pkg::*;
#(
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEFAULT
) (
  input  wire logic                      clk,
  input  wire logic                      rst,
  input  wire logic                      cfg_write,
  input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
  input  wire logic [CFG_BITS-1:0]       cfg_data,
  phd_sample_if.sink                     in,
  phd_result_if.source                   out
);

  cfg_t                   cfg;
  logic                   restart;

  logic                   in_valid;
  logic [SAMPLE_BITS-1:0] in_sample;
  logic                   advance;

  logic [SAMPLE_BITS-1:0] held_next;
  logic [PHASE_BITS-1:0]  phase_next;

  logic                   out_valid;
  logic [SAMPLE_BITS-1:0] out_held;
  logic [PHASE_BITS-1:0]  out_phase;

  // config registers
  assign restart = cfg_write && (cfg_reg_t'(cfg_index) == REG_TRACK_MINIMUM);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.track_minimum  <= 1'b0;
      cfg.hold_samples   <= HOLD_SAMPLES_RESET;
      cfg.decay_interval <= DECAY_INTERVAL_RESET;
      cfg.decay_step     <= DECAY_STEP_RESET;
    end else if (cfg_write) begin
      case (cfg_reg_t'(cfg_index))
        REG_TRACK_MINIMUM:  cfg.track_minimum  <= cfg_data[0];
        REG_HOLD_SAMPLES:   cfg.hold_samples   <= cfg_data;
        REG_DECAY_INTERVAL: cfg.decay_interval <= cfg_data;
        REG_DECAY_STEP:     cfg.decay_step     <= cfg_data;
        default:            cfg.decay_step     <= cfg.decay_step;
      endcase
    end
  end

  // input register
  assign advance  = in_valid && (!out_valid || out.ready);
  assign in.ready = !in_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (in.ready) begin
      in_valid <= in.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in.valid && in.ready) begin
      in_sample <= in.sample;
    end
  end

  phd_tracker #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_tracker (
    .clk             (clk),
    .rst             (rst),
    .step_en         (advance),
    .sample          (in_sample),
    .cfg             (cfg),
    .restart         (restart),
    .restart_minimum (cfg_data[0]),
    .held_next       (held_next),
    .phase_next      (phase_next)
  );

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (out.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_held  <= held_next;
      out_phase <= phase_next;
    end
  end

  assign out.valid      = out_valid;
  assign out.held_value = out_held;
  assign out.phase      = out_phase;

endmodule
`default_nettype wire
